FILE: hdl/snu_pkg.sv
// Shared types and constants for the split-nibble sample unpacker.
package snu_pkg;

  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int WORD_W      = 12;
  localparam int INDEX_W     = 20;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int PAYLOAD_W   = 21;
  localparam int QUOT_W      = 21;
  localparam int OUT_DATA_W  = WORD_W + INDEX_W;
  localparam int QUEUE_DEPTH = 4;

  // floor(x / 3) = (x * RECIP_3) >> RECIP_SHIFT for x below 2**24
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_3 = 24'd11184811;
  localparam int RECIP_SHIFT = 25;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SAMPLE_COUNT  = 1'b0,
    CFG_PAYLOAD_BYTES = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                 is_write;
    logic [BYTE_W-1:0]    data;
    logic [NIB_W-1:0]     nib_word;
    logic [NIB_W-1:0]     nib_store;
    logic [INDEX_W-1:0]   word_index;
    logic                 last;
  } entry_t;

endpackage

FILE: hdl/snu_front.sv
// Front end: configuration registers, byte counting and classification of each byte.
module snu_front #(
  parameter int MAX_HALF_WORDS = 524288,
  parameter int AW = 19,
  parameter int HW = 20,
  parameter int PW = 21
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [snu_pkg::BYTE_W-1:0]          s_tdata,
  input  logic                                s_tuser,
  input  logic                                cfg_we,
  input  logic [snu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [snu_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output snu_pkg::entry_t                     q_entry,
  output logic [AW-1:0]                       q_addr
);
  import snu_pkg::*;

  localparam int IXW = (PW > INDEX_W) ? PW : INDEX_W;
  localparam int CLW = QUOT_W + 2;
  localparam logic [CLW-1:0] LIMIT = CLW'(2 * MAX_HALF_WORDS);
  localparam int PRODW = PAYLOAD_W + 1 + RECIP_W;

  logic [CFG_DATA_W-1:0] sample_count;
  logic [QUOT_W-1:0]     from_payload;
  logic [PW-1:0]         pos;
  logic [PW-1:0]         pos_next;
  logic [BYTE_W-1:0]     held;
  logic [HW-1:0]         half;
  logic [PW-1:0]         three_half;

  logic [PRODW-1:0]      prod;
  logic [QUOT_W-1:0]     cnt_min;
  logic [QUOT_W-1:0]     cnt_even;
  logic [HW-1:0]         half_new;
  logic [PW-1:0]         three_new;
  logic [HW-1:0]         cur_half;
  logic [PW-1:0]         cur_three;
  logic [PW-1:0]         cur_two;
  logic [PW-1:0]         p;
  logic [PW-1:0]         ri;
  logic [IXW-1:0]        widx;
  logic                  accept;
  logic                  active;
  logic                  first_part;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // 2*payload/3 taken at the time of the write
  assign prod = PRODW'({cfg_data[PAYLOAD_W-1:0], 1'b0}) * PRODW'(RECIP_3);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      from_payload <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SAMPLE_COUNT:  sample_count <= cfg_data;
        CFG_PAYLOAD_BYTES: from_payload <= prod[RECIP_SHIFT +: QUOT_W];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_min = (sample_count < CFG_DATA_W'(from_payload))
              ? sample_count[QUOT_W-1:0] : from_payload;
    cnt_even = {cnt_min[QUOT_W-1:1], 1'b0};
    if (CLW'(cnt_even) > LIMIT) begin
      half_new = HW'(MAX_HALF_WORDS);
    end else begin
      half_new = HW'(cnt_even >> 1);
    end
    three_new = PW'(half_new) + PW'({half_new, 1'b0});

    cur_half  = s_tuser ? half_new : half;
    cur_three = s_tuser ? three_new : three_half;
    cur_two   = PW'({cur_half, 1'b0});
    p         = s_tuser ? '0 : pos;
    active    = p < cur_three;
    first_part = p < cur_two;
    ri        = p - cur_two;

    pos_next = active ? p + PW'(1) : p;

    q_push  = accept && active && (!first_part || p[0]);
    q_entry.data      = s_tdata;
    q_entry.nib_word  = held[BYTE_W-1 -: NIB_W];
    q_entry.nib_store = held[NIB_W-1:0];
    if (first_part) begin
      widx               = IXW'(p >> 1);
      q_entry.is_write   = 1'b1;
      q_entry.last       = 1'b0;
      q_addr             = AW'(p >> 1);
    end else begin
      widx               = IXW'(cur_half) + IXW'(ri);
      q_entry.is_write   = 1'b0;
      q_entry.last       = (ri + PW'(1)) == PW'(cur_half);
      q_addr             = AW'(ri);
    end
    q_entry.word_index = widx[INDEX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      held       <= '0;
      half       <= '0;
      three_half <= '0;
    end else if (accept) begin
      pos <= pos_next;
      if (s_tuser) begin
        half       <= half_new;
        three_half <= three_new;
      end
      if (active && first_part && !p[0]) begin
        held <= s_tdata;
      end
    end
  end

endmodule

FILE: hdl/snu_fifo.sv
// Short queue between the front end and the back end.
module snu_fifo #(
  parameter int WIDTH = 56
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  import snu_pkg::*;

  localparam int PTRW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;

  assign full      = count == CNTW'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTRW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/snu_back.sv
// Back end: nibble store access and the output register.
module snu_back #(
  parameter int MAX_HALF_WORDS = 524288,
  parameter int AW = 19
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  snu_pkg::entry_t                  q_entry,
  input  logic [AW-1:0]                    q_addr,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [snu_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tlast
);
  import snu_pkg::*;

  logic [NIB_W-1:0] nib_store [MAX_HALF_WORDS];
  logic [NIB_W-1:0] rd_nib;
  entry_t           r_entry;
  logic             r_valid;

  assign q_pop = q_valid && (!r_valid || m_tready);

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.is_write) begin
      nib_store[q_addr] <= q_entry.nib_store;
    end
    if (q_pop) begin
      rd_nib <= nib_store[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      r_entry <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (q_pop) begin
      r_valid <= 1'b1;
    end else if (m_tready) begin
      r_valid <= 1'b0;
    end
  end

  assign m_tvalid = r_valid;
  assign m_tlast  = r_entry.last;
  assign m_tdata  = {r_entry.word_index, r_entry.data,
                     r_entry.is_write ? r_entry.nib_word : rd_nib};

endmodule

FILE: hdl/split_nibble_sample_unpacker.sv
// Top level of the split-nibble sample unpacker.
//
// Input stream: one payload byte per transaction on s_tdata, s_tuser high on
// the first byte of a sample; this latches the word count from sample_count
// and payload_bytes (write those on the cfg port while the block is idle).
// Output stream: one decoded word per transaction, index beside it, m_tlast
// on the final word. Nibble bytes and bytes past the sample give no output.
// A word passes through the queue, then the store read and output register.
// Throughput: one byte per cycle while the queue is not full, bound by the
// single write/read port of the nibble store.
// A queue of four entries sits between the counting front end and the store
// side, so s_tready stays high while m_tready is low until the queue fills.
// Reset clears the count, position and queue; the nibble store is not
// cleared, since each entry is written before its sample reads it.
module split_nibble_sample_unpacker #(
  parameter int MAX_HALF_WORDS = 524288
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [snu_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] data_byte
  input  logic                              s_tuser,   // [0] first_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [snu_pkg::OUT_DATA_W-1:0]    m_tdata,   // [11:0] word, [31:12] word_index
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [snu_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [snu_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import snu_pkg::*;

  localparam int AW = (MAX_HALF_WORDS > 1) ? $clog2(MAX_HALF_WORDS) : 1;
  localparam int HW = $clog2(MAX_HALF_WORDS + 1);
  localparam int PW = $clog2(3 * MAX_HALF_WORDS + 1);
  localparam int QW = AW + $bits(entry_t);

  logic            q_full;
  logic            q_push;
  entry_t          f_entry;
  logic [AW-1:0]   f_addr;
  logic            q_pop;
  logic            q_valid;
  logic [QW-1:0]   q_data;
  entry_t          b_entry;
  logic [AW-1:0]   b_addr;

  snu_front #(
    .MAX_HALF_WORDS(MAX_HALF_WORDS),
    .AW(AW),
    .HW(HW),
    .PW(PW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_full(q_full),
    .q_push(q_push),
    .q_entry(f_entry),
    .q_addr(f_addr)
  );

  snu_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data({f_addr, f_entry}),
    .full(q_full),
    .pop(q_pop),
    .pop_data(q_data),
    .not_empty(q_valid)
  );

  assign b_addr  = q_data[QW-1 -: AW];
  assign b_entry = entry_t'(q_data[$bits(entry_t)-1:0]);

  snu_back #(
    .MAX_HALF_WORDS(MAX_HALF_WORDS),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_entry(b_entry),
    .q_addr(b_addr),
    .q_pop(q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

endmodule

FILE: hdl/snu_checker.sv
// Port-level checks for the split-nibble sample unpacker, bound to the top level.
module snu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // a stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // the final word always has an odd index
  a_last_odd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[12])
    else $error("last word on even index");

  // a word appearing on an idle output came from a byte taken in through the queue and output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("output without a matching input");

endmodule

bind split_nibble_sample_unpacker snu_checker u_snu_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tlast(m_tlast)
);
